### src/ubxfb_pkg.sv
// ----------------------------------------------------------------------------
// UBX frame builder package
// Shared types and constants for the frame builder front end, command queue
// and byte sequencer.
// ----------------------------------------------------------------------------
package ubxfb_pkg;

  // Frame constants.
  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;
  localparam logic [7:0] ERR_BYTE = 8'h00;

  // Default configuration.
  localparam int unsigned MAX_PAYLOAD_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Byte sequencer steps.
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] HDR_SYNC_ONE = 3'd0;
  localparam logic [STEP_W-1:0] HDR_SYNC_TWO = 3'd1;
  localparam logic [STEP_W-1:0] HDR_CLASS    = 3'd2;
  localparam logic [STEP_W-1:0] HDR_ID       = 3'd3;
  localparam logic [STEP_W-1:0] HDR_LEN_LO   = 3'd4;
  localparam logic [STEP_W-1:0] HDR_LEN_HI   = 3'd5;
  localparam logic [STEP_W-1:0] HDR_CK_A     = 3'd6;
  localparam logic [STEP_W-1:0] HDR_CK_B     = 3'd7;
  localparam logic [STEP_W-1:0] DATA_BYTE    = 3'd0;
  localparam logic [STEP_W-1:0] DATA_CK_A    = 3'd1;
  localparam logic [STEP_W-1:0] DATA_CK_B    = 3'd2;

  // Kind of work handed from the front end to the sequencer.
  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DATA,
    CMD_ERR
  } cmd_kind_t;

  // One queued command: everything the sequencer needs to emit its bytes.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] class_code;
    logic [7:0] msg_id;
    logic [7:0] len_lo;
    logic [7:0] len_hi;
    logic [7:0] data;
    logic       with_ck;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
  } cmd_t;

  // Queue status seen by the front end and the sequencer.
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

### src/ubxfb_front.sv
// ----------------------------------------------------------------------------
// UBX frame builder front end
// Accepts input transactions, keeps the running Fletcher-8 sums and frame
// bookkeeping, and turns each transaction into one queued command.
// ----------------------------------------------------------------------------
module ubxfb_front #(
  parameter int unsigned MAX_PAYLOAD = ubxfb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    action,
  input  logic [7:0]              class_code,
  input  logic [7:0]              msg_id,
  input  logic [15:0]             frame_len,
  input  logic [7:0]              payload_byte,
  input  ubxfb_pkg::queue_status_t q_status,
  output logic                    push,
  output ubxfb_pkg::cmd_t         push_cmd
);
  import ubxfb_pkg::*;

  localparam int unsigned LEFT_W = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]        sum_a;
  logic [7:0]        sum_b;
  logic [LEFT_W-1:0] bytes_left;
  logic              frame_open;

  logic [7:0]        sum_a_next;
  logic [7:0]        sum_b_next;
  logic [LEFT_W-1:0] bytes_left_next;
  logic              frame_open_next;

  logic              accept;
  logic              len_bad;
  logic [7:0]        a1, a2, a3, a4;
  logic [7:0]        b1, b2, b3, b4;
  logic [7:0]        pa, pb;

  // A transaction is taken whenever the queue has room for its command.
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;
  assign len_bad  = frame_len > 16'(MAX_PAYLOAD);

  // Header checksum over class, id and both length bytes, from cleared sums.
  always_comb begin
    a1 = class_code;
    b1 = a1;
    a2 = a1 + msg_id;
    b2 = b1 + a2;
    a3 = a2 + frame_len[7:0];
    b3 = b2 + a3;
    a4 = a3 + frame_len[15:8];
    b4 = b3 + a4;
  end

  // Payload byte folded into the running sums.
  always_comb begin
    pa = sum_a + payload_byte;
    pb = sum_b + pa;
  end

  // Classify the transaction and work out the next frame state.
  always_comb begin
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    bytes_left_next     = bytes_left;
    frame_open_next     = frame_open;
    push_cmd.kind       = CMD_ERR;
    push_cmd.class_code = class_code;
    push_cmd.msg_id     = msg_id;
    push_cmd.len_lo     = frame_len[7:0];
    push_cmd.len_hi     = frame_len[15:8];
    push_cmd.data       = payload_byte;
    push_cmd.with_ck    = 1'b0;
    push_cmd.ck_a       = pa;
    push_cmd.ck_b       = pb;
    if (!action) begin
      push_cmd.ck_a = a4;
      push_cmd.ck_b = b4;
      if (len_bad) begin
        frame_open_next = 1'b0;
        bytes_left_next = '0;
      end else begin
        push_cmd.kind   = CMD_HDR;
        sum_a_next      = a4;
        sum_b_next      = b4;
        if (frame_len == 16'd0) begin
          push_cmd.with_ck = 1'b1;
          frame_open_next  = 1'b0;
          bytes_left_next  = '0;
        end else begin
          frame_open_next = 1'b1;
          bytes_left_next = LEFT_W'(frame_len);
        end
      end
    end else if (frame_open && (bytes_left != '0)) begin
      push_cmd.kind   = CMD_DATA;
      sum_a_next      = pa;
      sum_b_next      = pb;
      bytes_left_next = bytes_left - LEFT_W'(1);
      if (bytes_left == LEFT_W'(1)) begin
        push_cmd.with_ck = 1'b1;
        frame_open_next  = 1'b0;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a      <= '0;
      sum_b      <= '0;
      bytes_left <= '0;
      frame_open <= 1'b0;
    end else if (accept) begin
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

  // An open frame always has payload still to come.
  a_open_left : assert property (@(posedge clk) disable iff (rst)
    frame_open == (bytes_left != '0))
    else $error("frame_open and bytes_left disagree");

  // The count never exceeds the configured maximum.
  a_left_max : assert property (@(posedge clk) disable iff (rst)
    bytes_left <= LEFT_W'(MAX_PAYLOAD))
    else $error("bytes_left above maximum payload");

  // The final payload byte closes the frame.
  a_last_close : assert property (@(posedge clk) disable iff (rst)
    (accept && action && frame_open && bytes_left == LEFT_W'(1)) |=> !frame_open)
    else $error("frame still open after its last payload byte");

endmodule

### src/ubxfb_queue.sv
// ----------------------------------------------------------------------------
// UBX frame builder command queue
// Small first-in first-out buffer of commands between the front end and the
// byte sequencer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ubxfb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  ubxfb_pkg::cmd_t          push_cmd,
  input  logic                     pop,
  output ubxfb_pkg::cmd_t          head,
  output ubxfb_pkg::queue_status_t status
);
  import ubxfb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full      = count == CNT_W'(DEPTH);
  assign status.not_empty = count != '0;
  assign head             = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/ubxfb_back.sv
// ----------------------------------------------------------------------------
// UBX frame builder byte sequencer
// Walks each queued command byte by byte into a registered output stage and
// marks the checksum end, errors and the last result of each transaction.
// ----------------------------------------------------------------------------
module ubxfb_back (
  input  logic                     clk,
  input  logic                     rst,
  input  ubxfb_pkg::cmd_t          head,
  input  ubxfb_pkg::queue_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_byte,
  output logic                     frame_end,
  output logic                     error,
  output logic                     run_last
);
  import ubxfb_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic [7:0]        sel_byte;
  logic              sel_end;
  logic              sel_err;
  logic              load;
  logic              at_last;

  // Pick the byte for the current step of the head command.
  always_comb begin
    sel_byte  = ERR_BYTE;
    sel_end   = 1'b0;
    sel_err   = 1'b0;
    last_step = HDR_SYNC_ONE;
    unique case (head.kind)
      CMD_HDR: begin
        last_step = head.with_ck ? HDR_CK_B : HDR_LEN_HI;
        sel_end   = step == HDR_CK_B;
        unique case (step)
          HDR_SYNC_ONE: sel_byte = SYNC_ONE;
          HDR_SYNC_TWO: sel_byte = SYNC_TWO;
          HDR_CLASS:    sel_byte = head.class_code;
          HDR_ID:       sel_byte = head.msg_id;
          HDR_LEN_LO:   sel_byte = head.len_lo;
          HDR_LEN_HI:   sel_byte = head.len_hi;
          HDR_CK_A:     sel_byte = head.ck_a;
          HDR_CK_B:     sel_byte = head.ck_b;
          default:      sel_byte = ERR_BYTE;
        endcase
      end
      CMD_DATA: begin
        last_step = head.with_ck ? DATA_CK_B : DATA_BYTE;
        sel_end   = step == DATA_CK_B;
        unique case (step)
          DATA_BYTE: sel_byte = head.data;
          DATA_CK_A: sel_byte = head.ck_a;
          DATA_CK_B: sel_byte = head.ck_b;
          default:   sel_byte = ERR_BYTE;
        endcase
      end
      default: begin
        sel_end = 1'b1;
        sel_err = 1'b1;
      end
    endcase
  end

  // Load the output stage from a non-empty queue whenever it is empty or being drained.
  assign load    = q_status.not_empty && (!out_valid || out_ready);
  assign at_last = step == last_step;
  assign pop     = load && at_last;

  // Control: output valid and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= at_last ? '0 : step + STEP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= sel_byte;
      frame_end <= sel_end;
      error     <= sel_err;
      run_last  <= at_last;
    end
  end

  // An error result stands alone and ends its frame.
  a_err_alone : assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (frame_end && run_last))
    else $error("error result not marked as frame end and last");

  // The checksum end is always the last result of its transaction.
  a_end_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last)
    else $error("frame end not on the last result");

  // Error results carry a zero byte.
  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (out_byte == ERR_BYTE))
    else $error("error result with a non-zero byte");

endmodule

### src/ubx_frame_builder.sv
// Each accepted transaction is queued, then loaded into the registered output
// stage. Throughput: one result byte per cycle while out_ready is high and
// the queue is not empty; a start gives 6 or 8 bytes, a payload byte 1, or 3
// when it closes the frame, an error 1.
// Input is taken every cycle while the QUEUE_DEPTH command queue has room.
// Reset (synchronous, active high) closes any frame and empties the queue.
// ----------------------------------------------------------------------------
// UBX frame builder
// Builds binary GNSS command frames with sync bytes, header, payload and a
// Fletcher-8 checksum, as a stream of output bytes.
// ----------------------------------------------------------------------------
module ubx_frame_builder #(
  parameter int unsigned MAX_PAYLOAD = ubxfb_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = ubxfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  class_code,
  input  logic [7:0]  msg_id,
  input  logic [15:0] frame_len,
  input  logic [7:0]  payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        error,
  output logic        run_last
);
  import ubxfb_pkg::*;

  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;
  queue_status_t q_status;

  // Front end: classification and checksum state.
  ubxfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .class_code  (class_code),
    .msg_id      (msg_id),
    .frame_len   (frame_len),
    .payload_byte(payload_byte),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Command queue between the two sides.
  ubxfb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  // Byte sequencer and output stage.
  ubxfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .frame_end(frame_end),
    .error    (error),
    .run_last (run_last)
  );

endmodule
